// ===== hw/rtl/bsim_pkg.sv =====
// Shared types and constants of the bank switch IRQ mapper.
// Used by the front decoder, the command queue, the divider, the back end and the top level.
package bsim_pkg;

  // Queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Remainder unit: one dividend bit per step over a 9-bit dividend
  localparam int unsigned DivWidth = 9;
  localparam int unsigned DivCntW  = $clog2(DivWidth);

  // Register write decode
  localparam logic [15:0] WrDecodeMask = 16'hE003;
  localparam logic [15:0] AddrPrg0     = 16'h8000;
  localparam logic [15:0] AddrPrg1     = 16'h8001;
  localparam logic [15:0] AddrChrW0    = 16'h8002;
  localparam logic [15:0] AddrChrW1    = 16'h8003;
  localparam logic [15:0] AddrChrN0    = 16'hA000;
  localparam logic [15:0] AddrChrN1    = 16'hA001;
  localparam logic [15:0] AddrChrN2    = 16'hA002;
  localparam logic [15:0] AddrChrN3    = 16'hA003;
  localparam logic [15:0] AddrMirror   = 16'hC000;
  localparam logic [15:0] AddrReload   = 16'hC001;
  localparam logic [15:0] AddrRestart  = 16'hC002;
  localparam logic [15:0] AddrEnable   = 16'hC003;

  localparam logic [7:0] PrgBankMask  = 8'h3F;
  localparam int unsigned MirrorBitPos = 6;
  localparam logic [7:0] CounterTop   = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CfgPrgTotal   = 2'd0;
  localparam logic [1:0] CfgChrTotal   = 2'd1;
  localparam logic [1:0] CfgFourScreen = 2'd2;

  localparam logic [7:0] PrgTotalReset = 8'd2;
  localparam logic [1:0] MirrorNotDriven = 2'd2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_PRG   = 2'd2,
    ACT_CHR   = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_PRG0,
    WR_PRG1,
    WR_CHRW0,
    WR_CHRW1,
    WR_CHRN0,
    WR_CHRN1,
    WR_CHRN2,
    WR_CHRN3,
    WR_MIRROR,
    WR_RELOAD,
    WR_RESTART,
    WR_ENABLE
  } wr_sel_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bank_number;
    logic       line_req;
    logic [1:0] mirror_mode;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    act_e       act;
    wr_sel_e    wsel;
    logic [2:0] win;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] prg_total;
    logic [7:0] chr_total;
    logic       nt_external;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] dividend;
    logic [7:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/bank_switch_irq_mapper.sv =====
// Top level of the bank switch IRQ mapper: configuration registers and the front/queue/back chain.
// Depends on bsim_pkg, bsim_front, bsim_queue and bsim_back.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o with in_data_i (action, address, write_data):
//   register write, scanline tick, program translate or character translate.
//   Every request yields exactly one result on out_valid_o/out_ready_i with out_data_o
//   (bank_number, line_req, mirror_mode), in request order.
//   The front decodes requests into a two-entry queue; the back executes one at a time.
//   Writes, ticks, fixed program windows and unbanked character reads pass from the queue
//   head straight to the result register; translates that reduce by the bank count first
//   pass through the 9-step remainder unit (one dividend bit per cycle).
//   The back end takes a new request only after its last result is in the result register.
//   A stalled receiver holds the result register; the queue then fills and in_ready_o drops.
//   Reset clears all bank registers, the line counter, enable and pending flag, sets the
//   program bank total to 2 and the other configuration registers to 0.
//   Configuration (APB, byte address 4*index): 0 program bank total, 1 character bank
//   total, 2 four-screen mode. Write only while no request is in flight.
module bank_switch_irq_mapper import bsim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  cmd_t    push_cmd, head_cmd;
  logic    push, pop;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_total   <= PrgTotalReset;
      cfg_q.chr_total   <= '0;
      cfg_q.nt_external <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        CfgPrgTotal:   cfg_q.prg_total   <= pwdata[7:0];
        CfgChrTotal:   cfg_q.chr_total   <= pwdata[7:0];
        CfgFourScreen: cfg_q.nt_external <= pwdata[0];
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CfgPrgTotal:   prdata = {24'b0, cfg_q.prg_total};
      CfgChrTotal:   prdata = {24'b0, cfg_q.chr_total};
      CfgFourScreen: prdata = {31'b0, cfg_q.nt_external};
      default:       prdata = '0;
    endcase
  end

  bsim_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  bsim_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  bsim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  a_nt_external: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cfg_q.nt_external) |-> (out_data_o.mirror_mode == MirrorNotDriven))
    else $error("mirroring driven in four-screen mode");

  a_mirror_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.mirror_mode != 2'd3))
    else $error("illegal mirror code on result");

endmodule

// ===== hw/rtl/bsim_front.sv =====
// Front end: accepts requests and classifies them into queue commands.
// Depends on bsim_pkg.
module bsim_front import bsim_pkg::*; (
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic [15:0] masked;

  assign masked     = in_data_i.address & WrDecodeMask;
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd_o.act  = act_e'(in_data_i.action);
    cmd_o.data = in_data_i.write_data;
    cmd_o.wsel = WR_NONE;
    cmd_o.win  = 3'd0;
    case (cmd_o.act)
      ACT_WRITE: begin
        case (masked)
          AddrPrg0:    cmd_o.wsel = WR_PRG0;
          AddrPrg1:    cmd_o.wsel = WR_PRG1;
          AddrChrW0:   cmd_o.wsel = WR_CHRW0;
          AddrChrW1:   cmd_o.wsel = WR_CHRW1;
          AddrChrN0:   cmd_o.wsel = WR_CHRN0;
          AddrChrN1:   cmd_o.wsel = WR_CHRN1;
          AddrChrN2:   cmd_o.wsel = WR_CHRN2;
          AddrChrN3:   cmd_o.wsel = WR_CHRN3;
          AddrMirror:  cmd_o.wsel = WR_MIRROR;
          AddrReload:  cmd_o.wsel = WR_RELOAD;
          AddrRestart: cmd_o.wsel = WR_RESTART;
          AddrEnable:  cmd_o.wsel = WR_ENABLE;
          default:     cmd_o.wsel = WR_NONE;
        endcase
      end
      ACT_PRG: cmd_o.win = {1'b0, in_data_i.address[14:13]};
      ACT_CHR: cmd_o.win = in_data_i.address[12:10];
      default: cmd_o.win = 3'd0;
    endcase
  end

endmodule

// ===== hw/rtl/bsim_queue.sv =====
// Short command queue between the front and back ends.
// Depends on bsim_pkg.
module bsim_queue import bsim_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (QAw+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bsim_mod.sv =====
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Depends on bsim_pkg. Divisor must be nonzero.
module bsim_mod import bsim_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivWidth-1:0] dvd_q;
  logic [7:0]          div_q;
  logic [7:0]          rem_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic [8:0]          trial;
  logic [8:0]          diff;
  logic [7:0]          rem_d;

  assign trial = {rem_q, dvd_q[DivWidth-1]};
  assign diff  = trial - {1'b0, div_q};
  // Keep the trial value when it is below the divisor
  assign rem_d = (trial >= {1'b0, div_q}) ? diff[7:0] : trial[7:0];

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvd_q  <= req_i.dividend;
        div_q  <= req_i.divisor;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[DivWidth-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivWidth - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bsim_back.sv =====
// Back end: executes queued commands against the mapper state and drives the result register.
// Depends on bsim_pkg and bsim_mod.
module bsim_back import bsim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_stat_t   q_stat_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEND
  } state_e;

  state_e    state_q;
  logic [5:0] prg_bank_q [2];
  logic [7:0] chr_wide_q [2];
  logic [7:0] chr_narrow_q [4];
  logic       mirror_q;
  logic [7:0] reload_q;
  logic [7:0] counter_q;
  logic       enable_q;
  logic       irq_q;
  logic [7:0] res_q;
  logic       out_valid_q;
  out_item_t  out_q;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       need_div;
  logic [7:0] direct_bank;

  assign pop_o       = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Classify the head command into a direct answer or a remainder job
  always_comb begin
    need_div         = 1'b0;
    direct_bank      = 8'd0;
    div_req.dividend = '0;
    div_req.divisor  = cfg_i.prg_total;
    case (cmd_i.act)
      ACT_PRG: begin
        case (cmd_i.win[1:0])
          2'd2:    direct_bank = cfg_i.prg_total - 8'd2;
          2'd3:    direct_bank = cfg_i.prg_total - 8'd1;
          default: begin
            need_div         = (cfg_i.prg_total != 8'd0);
            div_req.dividend = {3'b0, prg_bank_q[cmd_i.win[0]]};
          end
        endcase
      end
      ACT_CHR: begin
        div_req.divisor = cfg_i.chr_total;
        if (cfg_i.chr_total == 8'd0) begin
          direct_bank = {5'b0, cmd_i.win};
        end else begin
          need_div = 1'b1;
          if (!cmd_i.win[2]) begin
            div_req.dividend = {chr_wide_q[cmd_i.win[1]], cmd_i.win[0]};
          end else begin
            div_req.dividend = {1'b0, chr_narrow_q[cmd_i.win[1:0]]};
          end
        end
      end
      default: begin
        need_div    = 1'b0;
        direct_bank = 8'd0;
      end
    endcase
    div_req.start = pop_o && need_div;
  end

  bsim_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      prg_bank_q[0]   <= '0;
      prg_bank_q[1]   <= '0;
      chr_wide_q[0]   <= '0;
      chr_wide_q[1]   <= '0;
      chr_narrow_q[0] <= '0;
      chr_narrow_q[1] <= '0;
      chr_narrow_q[2] <= '0;
      chr_narrow_q[3] <= '0;
      mirror_q        <= 1'b0;
      reload_q        <= '0;
      counter_q       <= '0;
      enable_q        <= 1'b0;
      irq_q           <= 1'b0;
      res_q           <= '0;
      out_valid_q     <= 1'b0;
      out_q           <= '0;
    end else begin
      // Drop valid on handshake unless a new result is loaded this cycle
      if (out_valid_q && out_ready_i && (state_q != ST_SEND)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            res_q   <= direct_bank;
            state_q <= need_div ? ST_DIV : ST_SEND;
            if (cmd_i.act == ACT_WRITE) begin
              case (cmd_i.wsel)
                WR_PRG0:     prg_bank_q[0]   <= cmd_i.data[5:0] & PrgBankMask[5:0];
                WR_PRG1:     prg_bank_q[1]   <= cmd_i.data[5:0] & PrgBankMask[5:0];
                WR_CHRW0:    chr_wide_q[0]   <= cmd_i.data;
                WR_CHRW1:    chr_wide_q[1]   <= cmd_i.data;
                WR_CHRN0:    chr_narrow_q[0] <= cmd_i.data;
                WR_CHRN1:    chr_narrow_q[1] <= cmd_i.data;
                WR_CHRN2:    chr_narrow_q[2] <= cmd_i.data;
                WR_CHRN3:    chr_narrow_q[3] <= cmd_i.data;
                WR_MIRROR:   mirror_q        <= cmd_i.data[MirrorBitPos];
                WR_RELOAD:   reload_q        <= cmd_i.data;
                WR_RESTART: begin
                  counter_q <= reload_q;
                  irq_q     <= 1'b0;
                end
                WR_ENABLE:   enable_q        <= 1'b1;
                default:     enable_q        <= enable_q;
              endcase
            end else if (cmd_i.act == ACT_TICK && enable_q) begin
              // Wrap: reload, stop counting, raise the request
              if (counter_q == CounterTop) begin
                counter_q <= reload_q;
                enable_q  <= 1'b0;
                irq_q     <= 1'b1;
              end else begin
                counter_q <= counter_q + 8'd1;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res_q   <= div_rsp.rem;
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          // Hold until the result register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.bank_number <= res_q;
            out_q.line_req    <= irq_q;
            out_q.mirror_mode <= cfg_i.nt_external ? MirrorNotDriven : {1'b0, mirror_q};
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for bank_switch_irq_mapper: a directed table, then random
// requests under several bank totals, checked against a predictor kept in step.
// Depends on bsim_pkg and the bank_switch_irq_mapper RTL.
module tb;
  import bsim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases = 8;
  localparam int PhaseItems = 110;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bank_switch_irq_mapper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // Predicted mapper state and configuration, reset values
  logic [7:0] prg_total = PrgTotalReset;
  logic [7:0] chr_total = 8'd0;
  logic       nt_external = 1'b0;
  logic [5:0] prg_sel [2] = '{default: '0};
  logic [7:0] chr_pair [2] = '{default: '0};
  logic [7:0] chr_single [4] = '{default: '0};
  logic       mirror_h = 1'b0;
  logic [7:0] reload_val = 8'd0;
  logic [7:0] line_cnt = 8'd0;
  logic       count_on = 1'b0;
  logic       irq_flag = 1'b0;

  out_item_t owed_results [$];
  int        miss_count = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        rx_hold = 0;

  typedef struct packed {
    act_e       act;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        chk;
    out_item_t   exp;
  } dir_row_t;

  // Reset configuration: program total 2, no character banking, mirroring driven
  dir_row_t directed_rows [26] = '{
    '{ACT_PRG,   16'h8000, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_PRG,   16'hA000, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_PRG,   16'hC000, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_PRG,   16'hFFFF, 8'hFF, 1'b1, '{8'd1, 1'b0, 2'd0}},
    '{ACT_PRG,   16'h6000, 8'h00, 1'b1, '{8'd1, 1'b0, 2'd0}},
    '{ACT_CHR,   16'h0000, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_CHR,   16'hFFFF, 8'hFF, 1'b1, '{8'd7, 1'b0, 2'd0}},
    '{ACT_CHR,   16'h1000, 8'h00, 1'b1, '{8'd4, 1'b0, 2'd0}},
    '{ACT_TICK,  16'h0000, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_WRITE, 16'hE000, 8'hFF, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_WRITE, 16'h8000, 8'hFF, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_PRG,   16'h8000, 8'h00, 1'b1, '{8'd1, 1'b0, 2'd0}},
    '{ACT_WRITE, 16'h9FFF, 8'hAB, 1'b0, '0},
    '{ACT_WRITE, 16'hA003, 8'hFF, 1'b0, '0},
    '{ACT_WRITE, 16'hC000, 8'h40, 1'b1, '{8'd0, 1'b0, 2'd1}},
    '{ACT_WRITE, 16'hC001, 8'hFE, 1'b1, '{8'd0, 1'b0, 2'd1}},
    '{ACT_WRITE, 16'hC002, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd1}},
    '{ACT_TICK,  16'hFFFF, 8'hFF, 1'b1, '{8'd0, 1'b0, 2'd1}},
    '{ACT_WRITE, 16'hC003, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd1}},
    '{ACT_TICK,  16'h0000, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd1}},
    '{ACT_TICK,  16'h0000, 8'h00, 1'b1, '{8'd0, 1'b1, 2'd1}},
    '{ACT_TICK,  16'h0000, 8'h00, 1'b1, '{8'd0, 1'b1, 2'd1}},
    '{ACT_WRITE, 16'hDFFF, 8'h00, 1'b1, '{8'd0, 1'b1, 2'd1}},
    '{ACT_WRITE, 16'hC000, 8'hBF, 1'b1, '{8'd0, 1'b1, 2'd0}},
    '{ACT_WRITE, 16'hC002, 8'h00, 1'b1, '{8'd0, 1'b0, 2'd0}},
    '{ACT_PRG,   16'h2000, 8'h00, 1'b0, '0}
  };

  logic [15:0] reg_addrs [12] = '{AddrPrg0, AddrPrg1, AddrChrW0, AddrChrW1,
                                  AddrChrN0, AddrChrN1, AddrChrN2, AddrChrN3,
                                  AddrMirror, AddrReload, AddrRestart, AddrEnable};

  logic [7:0] phase_prg [NumPhases] = '{8'd254, 8'd2, 8'd37, 8'd0,
                                        8'd128, 8'd3, 8'd254, 8'd2};
  logic [7:0] phase_chr [NumPhases] = '{8'd248, 8'd1, 8'd0, 8'd5,
                                        8'd200, 8'd248, 8'd7, 8'd0};
  logic       phase_four [NumPhases] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                         1'b0, 1'b1, 1'b0, 1'b0};
  int         mode_tx [4] = '{0, 51, 0, 38};
  int         mode_rx [4] = '{0, 0, 51, 38};

  function automatic logic [7:0] bank_mod(input logic [8:0] v, input logic [7:0] n);
    if (n == 8'd0) return 8'd0;
    return 8'(v % n);
  endfunction

  // Apply one request to the predicted state and return the result it yields
  function automatic out_item_t mapper_apply(input in_item_t it);
    logic [2:0] cw;
    logic [7:0] bank;
    out_item_t  r;
    bank = 8'd0;
    cw = it.address[12:10];
    case (act_e'(it.action))
      ACT_WRITE: begin
        case (it.address & WrDecodeMask)
          AddrPrg0:    prg_sel[0] = it.write_data[5:0];
          AddrPrg1:    prg_sel[1] = it.write_data[5:0];
          AddrChrW0:   chr_pair[0] = it.write_data;
          AddrChrW1:   chr_pair[1] = it.write_data;
          AddrChrN0:   chr_single[0] = it.write_data;
          AddrChrN1:   chr_single[1] = it.write_data;
          AddrChrN2:   chr_single[2] = it.write_data;
          AddrChrN3:   chr_single[3] = it.write_data;
          AddrMirror:  mirror_h = it.write_data[MirrorBitPos];
          AddrReload:  reload_val = it.write_data;
          AddrRestart: begin
            line_cnt = reload_val;
            irq_flag = 1'b0;
          end
          AddrEnable:  count_on = 1'b1;
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (count_on) begin
          if (line_cnt == CounterTop) begin
            line_cnt = reload_val;
            count_on = 1'b0;
            irq_flag = 1'b1;
          end else begin
            line_cnt = line_cnt + 8'd1;
          end
        end
      end
      ACT_PRG: begin
        case (it.address[14:13])
          2'd0: bank = bank_mod({3'd0, prg_sel[0]}, prg_total);
          2'd1: bank = bank_mod({3'd0, prg_sel[1]}, prg_total);
          2'd2: bank = prg_total - 8'd2;
          default: bank = prg_total - 8'd1;
        endcase
      end
      default: begin
        // wide windows pair up as 2*bank + low window bit
        if (chr_total == 8'd0) bank = {5'd0, cw};
        else if (!cw[2]) bank = bank_mod({chr_pair[cw[1]], cw[0]}, chr_total);
        else bank = bank_mod({1'b0, chr_single[cw[1:0]]}, chr_total);
      end
    endcase
    r.bank_number = bank;
    r.line_req    = irq_flag;
    r.mirror_mode = nt_external ? MirrorNotDriven : {1'b0, mirror_h};
    return r;
  endfunction

  task automatic send_item(input in_item_t item, input logic chk, input out_item_t typed);
    int        gap;
    out_item_t want;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    want = mapper_apply(item);
    owed_results.push_back(chk ? typed : want);
  endtask

  task automatic drain();
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CfgPrgTotal:   prg_total = val;
      CfgChrTotal:   chr_total = val;
      CfgFourScreen: nt_external = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        if (miss_count < 10)
          $display("%0t: result with none owed: bank=%0d irq=%0d mirror=%0d", $realtime,
                   out_data_o.bank_number, out_data_o.line_req, out_data_o.mirror_mode);
        miss_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_data_o.bank_number !== want.bank_number ||
            out_data_o.line_req !== want.line_req ||
            out_data_o.mirror_mode !== want.mirror_mode) begin
          if (miss_count < 10)
            $display("%0t: want bank=%0d irq=%0d mirror=%0d, got bank=%0d irq=%0d mirror=%0d",
                     $realtime, want.bank_number, want.line_req, want.mirror_mode,
                     out_data_o.bank_number, out_data_o.line_req, out_data_o.mirror_mode);
          miss_count++;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    int        pick;
    int        sel;
    out_item_t none;
    none = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      it.action     = directed_rows[k].act;
      it.address    = directed_rows[k].addr;
      it.write_data = directed_rows[k].data;
      send_item(it, directed_rows[k].chk, directed_rows[k].exp);
    end

    for (int p = 0; p < NumPhases; p++) begin
      in_valid_i <= 1'b0;
      drain();
      cfg_write(CfgPrgTotal, phase_prg[p]);
      cfg_write(CfgChrTotal, phase_chr[p]);
      cfg_write(CfgFourScreen, {7'd0, phase_four[p]});
      tx_idle_pct  = mode_tx[p % 4];
      rx_stall_pct = mode_rx[p % 4];
      for (int n = 0; n < PhaseItems; n++) begin
        // hold the receiver off long enough to back the queue up into the input
        if (p == 0 && n == 30) rx_hold = 300;
        if (p == 5 && n == 60) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (owed_results.size() != 0);
        end
        pick          = $urandom_range(99);
        it.address    = 16'($urandom_range(65535));
        it.write_data = 8'($urandom_range(255));
        if (pick < 45) begin
          it.action = ACT_WRITE;
          sel = $urandom_range(15);
          // steer most writes onto decoded registers, keep the spare address bits random
          if (sel < 12) it.address = (it.address & ~WrDecodeMask) | reg_addrs[sel];
          else if (sel == 14) it.address = (it.address & ~WrDecodeMask) | AddrEnable;
          else if (sel == 15) it.address = (it.address & ~WrDecodeMask) | AddrRestart;
          // high reload values reach the counter top within a few ticks
          if ((it.address & WrDecodeMask) == AddrReload && $urandom_range(1) == 1)
            it.write_data[7:3] = 5'h1F;
        end else if (pick < 70) begin
          it.action = ACT_TICK;
        end else if (pick < 85) begin
          it.action = ACT_PRG;
        end else begin
          it.action = ACT_CHR;
        end
        send_item(it, 1'b0, none);
      end
    end

    in_valid_i <= 1'b0;
    drain();
    if (miss_count == 0) begin
      $display("bank_switch_irq_mapper: match");
    end else begin
      $display("bank_switch_irq_mapper: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("bank_switch_irq_mapper: mismatch");
    $finish;
  end

endmodule
